>>> hw/rtl/pfdm_pkg.sv
`default_nettype none

package pfdm_pkg;

  localparam int CNT_W_DEF   = 16;
  localparam int RATE_W      = 24;
  localparam logic [RATE_W-1:0] RATE_RST = 24'd8000000;

  // frequency numerator is rate * 100, duty numerator is high time * 10000
  localparam int FREQ_SCALE  = 100;
  localparam int DUTY_SCALE  = 10000;
  localparam int FREQ_NUM_W  = 31;   // bits of (2^24-1) * 100
  localparam int DUTY_SCALE_W = 14;  // 10000 < 2^14

  localparam int FREQ_W      = 30;   // holds 999999999
  localparam int DUTY_W      = 14;   // holds 9999
  localparam int FREQ_MAX    = 999999999;
  localparam int DUTY_MAX    = 9999;
  localparam int FREQ_DIGITS = 9;
  localparam int DUTY_DIGITS = 4;
  localparam int LINE_LEN    = 19;

  typedef struct packed {
    logic tick;
    logic load_f;
    logic load_d;
    logic div_step;
    logic store_f;
    logic store_d;
    logic bcd_step;
    logic emit_next;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_char;
  } dp_stat_t;

  // dividend width: wide enough for both numerators
  function automatic int calc_num_w(input int cw);
    calc_num_w = (cw + DUTY_SCALE_W > FREQ_NUM_W) ? cw + DUTY_SCALE_W : FREQ_NUM_W;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pfdm_if.sv
`default_nettype none

interface pfdm_in_if;
  logic valid;
  logic ready;
  logic action;
  logic pin_level;
  modport source(output valid, action, pin_level, input ready);
  modport sink(input valid, action, pin_level, output ready);
endinterface

interface pfdm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  modport source(output valid, out_char, last_char, input ready);
  modport sink(input valid, out_char, last_char, output ready);
endinterface

interface pfdm_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] tick_rate_hz;
  modport source(output valid, tick_rate_hz, input ready);
  modport sink(input valid, tick_rate_hz, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pfdm_ctrl.sv
`default_nettype none

module pfdm_ctrl #(
  parameter int COUNTER_WIDTH = pfdm_pkg::CNT_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pfdm_pkg::dp_stat_t  stat,
  output pfdm_pkg::ctl_cmd_t  cmd
);
  import pfdm_pkg::*;

  localparam int NUM_W = calc_num_w(COUNTER_WIDTH);
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LDF,
    S_DIVF,
    S_SVF,
    S_LDD,
    S_DIVD,
    S_SVD,
    S_BCD,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, out_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.tick = in_acc && !in_action;
        if (in_acc && in_action) begin
          state_nxt = S_LDF;
        end
      end
      S_LDF: begin
        cmd.load_f = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIVF;
      end
      S_DIVF: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_SVF;
        end
      end
      S_SVF: begin
        cmd.store_f = 1'b1;
        state_nxt   = S_LDD;
      end
      S_LDD: begin
        cmd.load_d = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIVD;
      end
      S_DIVD: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_SVD;
        end
      end
      S_SVD: begin
        cmd.store_d = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_BCD;
      end
      S_BCD: begin
        cmd.bcd_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FREQ_W - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_next = out_acc;
        if (out_acc && stat.last_char) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pfdm_dpath.sv
`default_nettype none

module pfdm_dpath #(
  parameter int COUNTER_WIDTH = pfdm_pkg::CNT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfdm_pkg::ctl_cmd_t          cmd,
  output pfdm_pkg::dp_stat_t          stat,
  input  logic                        pin_level,
  input  logic                        cfg_we,
  input  logic [pfdm_pkg::RATE_W-1:0] cfg_rate,
  output logic [7:0]                  out_char,
  output logic                        last_char
);
  import pfdm_pkg::*;

  localparam int CW     = COUNTER_WIDTH;
  localparam int NUM_W  = calc_num_w(COUNTER_WIDTH);
  localparam int FBCD_W = 4 * FREQ_DIGITS;
  localparam int DBCD_W = 4 * DUTY_DIGITS;
  localparam int IDX_W  = $clog2(LINE_LEN);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  logic [RATE_W-1:0] rate_r;
  logic [CW-1:0]     tick_cnt_r, period_r, high_r, cnt_inc;
  logic              last_r;

  logic [NUM_W-1:0]  num_r;
  logic [CW:0]       rem_r, rem_sh;
  logic [CW+1:0]     diff;
  logic              ge;

  logic [FREQ_W-1:0] freq_r, duty_r;
  logic [FBCD_W-1:0] fbcd_r, fadj;
  logic [DBCD_W-1:0] dbcd_r, dadj;
  logic [IDX_W-1:0]  idx_r;

  // measurement state
  assign cnt_inc = tick_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= RATE_RST;
      tick_cnt_r <= '0;
      period_r   <= '0;
      high_r     <= '0;
      last_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_rate;
      end
      if (cmd.tick) begin
        last_r <= pin_level;
        if (pin_level && !last_r) begin
          period_r   <= cnt_inc;
          tick_cnt_r <= '0;
        end else begin
          tick_cnt_r <= cnt_inc;
          if (!pin_level && last_r) begin
            high_r <= cnt_inc;
          end
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle; quotient shifts into num_r
  assign rem_sh = {rem_r[CW-1:0], num_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, period_r};
  assign ge     = !diff[CW+1];

  // double dabble adjust
  always_comb begin
    fadj = fbcd_r;
    for (int i = 0; i < FREQ_DIGITS; i++) begin
      if (fadj[4*i +: 4] >= 4'd5) begin
        fadj[4*i +: 4] = fadj[4*i +: 4] + 4'd3;
      end
    end
    dadj = dbcd_r;
    for (int i = 0; i < DUTY_DIGITS; i++) begin
      if (dadj[4*i +: 4] >= 4'd5) begin
        dadj[4*i +: 4] = dadj[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_f) begin
      num_r <= NUM_W'(rate_r) * NUM_W'(FREQ_SCALE);
      rem_r <= '0;
    end else if (cmd.load_d) begin
      num_r <= NUM_W'(high_r) * NUM_W'(DUTY_SCALE);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[CW:0] : rem_sh;
    end

    // zero period prints zeros; over-range values saturate
    if (cmd.store_f) begin
      if (period_r == '0) begin
        freq_r <= '0;
      end else if (num_r > NUM_W'(FREQ_MAX)) begin
        freq_r <= FREQ_W'(FREQ_MAX);
      end else begin
        freq_r <= num_r[FREQ_W-1:0];
      end
    end else if (cmd.bcd_step) begin
      freq_r <= {freq_r[FREQ_W-2:0], 1'b0};
    end

    if (cmd.store_d) begin
      if (period_r == '0) begin
        duty_r <= '0;
      end else if (num_r > NUM_W'(DUTY_MAX)) begin
        duty_r <= FREQ_W'(DUTY_MAX);
      end else begin
        duty_r <= FREQ_W'(num_r[DUTY_W-1:0]);
      end
      fbcd_r <= '0;
      dbcd_r <= '0;
    end else if (cmd.bcd_step) begin
      duty_r <= {duty_r[FREQ_W-2:0], 1'b0};
      fbcd_r <= {fadj[FBCD_W-2:0], freq_r[FREQ_W-1]};
      dbcd_r <= {dadj[DBCD_W-2:0], duty_r[FREQ_W-1]};
    end

    if (cmd.store_d) begin
      idx_r <= '0;
    end else if (cmd.emit_next) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // line layout: fffffff.dd:dd.dd%\r\n
  always_comb begin
    case (idx_r)
      5'd0:    out_char = CH_ZERO | {4'h0, fbcd_r[4*8 +: 4]};
      5'd1:    out_char = CH_ZERO | {4'h0, fbcd_r[4*7 +: 4]};
      5'd2:    out_char = CH_ZERO | {4'h0, fbcd_r[4*6 +: 4]};
      5'd3:    out_char = CH_ZERO | {4'h0, fbcd_r[4*5 +: 4]};
      5'd4:    out_char = CH_ZERO | {4'h0, fbcd_r[4*4 +: 4]};
      5'd5:    out_char = CH_ZERO | {4'h0, fbcd_r[4*3 +: 4]};
      5'd6:    out_char = CH_ZERO | {4'h0, fbcd_r[4*2 +: 4]};
      5'd7:    out_char = CH_DOT;
      5'd8:    out_char = CH_ZERO | {4'h0, fbcd_r[4*1 +: 4]};
      5'd9:    out_char = CH_ZERO | {4'h0, fbcd_r[4*0 +: 4]};
      5'd10:   out_char = CH_COLON;
      5'd11:   out_char = CH_ZERO | {4'h0, dbcd_r[4*3 +: 4]};
      5'd12:   out_char = CH_ZERO | {4'h0, dbcd_r[4*2 +: 4]};
      5'd13:   out_char = CH_DOT;
      5'd14:   out_char = CH_ZERO | {4'h0, dbcd_r[4*1 +: 4]};
      5'd15:   out_char = CH_ZERO | {4'h0, dbcd_r[4*0 +: 4]};
      5'd16:   out_char = CH_PCT;
      5'd17:   out_char = CH_CR;
      5'd18:   out_char = CH_LF;
      default: out_char = CH_LF;
    endcase
  end

  assign last_char      = (idx_r == IDX_W'(LINE_LEN - 1));
  assign stat.last_char = last_char;

endmodule

`default_nettype wire

>>> hw/rtl/pulse_frequency_duty_meter_unit.sv
`default_nettype none

// Frequency and duty-cycle meter. Each tick word (action 0) samples the pin and
// advances a free-running COUNTER_WIDTH-bit counter; ticks are taken one per
// clock while no report is in progress. A rising edge latches the period and
// clears the counter, a falling edge latches the high time. A report word
// (action 1) produces the 19-word line "fffffff.dd:dd.dd%\r\n": frequency =
// tick_rate_hz*100/period and duty = 10000*high/period, both truncated, all
// zeros for a zero period, saturated at 9999999.99 and 99.99. The report runs
// the shared one-bit-per-cycle divider twice over an N-bit dividend, N =
// max(31, COUNTER_WIDTH + 14), then the 30-step binary-to-BCD shifter, then
// sends one character per clock as the sink takes them; the input is held
// off until the line feed is taken. tick_rate_hz may be written at any time
// the unit is idle; the cfg port is always ready.
module pulse_frequency_duty_meter_unit #(
  parameter int COUNTER_WIDTH = pfdm_pkg::CNT_W_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pfdm_in_if.sink     in_if,
  pfdm_out_if.source  out_if,
  pfdm_cfg_if.sink    cfg_if
);
  import pfdm_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_if.ready = 1'b1;

  pfdm_ctrl #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_action (in_if.action),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfdm_dpath #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .pin_level (in_if.pin_level),
    .cfg_we    (cfg_if.valid),
    .cfg_rate  (cfg_if.tick_rate_hz),
    .out_char  (out_if.out_char),
    .last_char (out_if.last_char)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input ready while a line is being sent");

  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.action) |=> !in_if.ready)
    else $error("input still ready after a report word");

  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && out_if.last_char) |=> in_if.ready)
    else $error("input not ready after line feed");

  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && !in_if.action) |=> !out_if.valid)
    else $error("output word after a tick");
`endif

endmodule

`default_nettype wire

>>> tb/sv/pfdm_tb_pkg.sv
`timescale 1ns / 100ps

package pfdm_tb_pkg;

  // action field of an input word
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

endpackage

>>> tb/sv/pfdm_line_checker.sv
`timescale 1ns / 100ps

// Watches all three channels, keeps its own copy of the meter state and
// compares every character word of the report line against the prediction.
module pfdm_line_checker #(
  parameter int CNT_W = pfdm_pkg::CNT_W_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pfdm_in_if   in_if,
  pfdm_out_if  out_if,
  pfdm_cfg_if  cfg_if,
  output int   mismatches,
  output int   words_pending
);
  import pfdm_tb_pkg::*;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } line_char_t;

  line_char_t expected_chars[$];

  logic [pfdm_pkg::RATE_W-1:0] rate_hz;
  logic [CNT_W-1:0]            ticks_since_rise;
  logic [CNT_W-1:0]            period_len;
  logic [CNT_W-1:0]            high_len;
  logic                        pin_prev;

  initial mismatches = 0;

  task automatic put_char(input logic [7:0] c, input logic is_last);
    line_char_t w;
    w.ch = c;
    w.is_last = is_last;
    expected_chars.push_back(w);
  endtask

  // ndig decimal digits, point before the last two
  task automatic put_fixed(input logic [31:0] value, input int ndig);
    logic [7:0]  digs[pfdm_pkg::FREQ_DIGITS];
    logic [31:0] v;
    v = value;
    for (int i = ndig - 1; i >= 0; i--) begin
      digs[i] = CH_ZERO + 8'(v % 10);
      v = v / 10;
    end
    for (int i = 0; i < ndig; i++) begin
      if (i == ndig - 2) put_char(CH_POINT, 1'b0);
      put_char(digs[i], 1'b0);
    end
  endtask

  task automatic predict_report_line();
    logic [63:0] fq;
    logic [63:0] dq;
    logic [31:0] freq;
    logic [31:0] duty;
    freq = '0;
    duty = '0;
    // zero period leaves both figures at zero
    if (period_len != '0) begin
      fq = (64'(rate_hz) * 64'(pfdm_pkg::FREQ_SCALE)) / 64'(period_len);
      dq = (64'(high_len) * 64'(pfdm_pkg::DUTY_SCALE)) / 64'(period_len);
      freq = (fq > 64'(pfdm_pkg::FREQ_MAX)) ? 32'(pfdm_pkg::FREQ_MAX) : fq[31:0];
      duty = (dq > 64'(pfdm_pkg::DUTY_MAX)) ? 32'(pfdm_pkg::DUTY_MAX) : dq[31:0];
    end
    put_fixed(freq, pfdm_pkg::FREQ_DIGITS);
    put_char(CH_COLON, 1'b0);
    put_fixed(duty, pfdm_pkg::DUTY_DIGITS);
    put_char(CH_PERCENT, 1'b0);
    put_char(CH_CR, 1'b0);
    put_char(CH_LF, 1'b1);
  endtask

  always @(posedge clk) begin
    line_char_t exp_w;
    if (!rst_n) begin
      rate_hz          = pfdm_pkg::RATE_RST;
      ticks_since_rise = '0;
      period_len       = '0;
      high_len         = '0;
      pin_prev         = 1'b0;
      expected_chars.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) rate_hz = cfg_if.tick_rate_hz;

      if (in_if.valid && in_if.ready) begin
        if (in_if.action == ACT_TICK) begin
          ticks_since_rise = ticks_since_rise + 1'b1;
          if (in_if.pin_level && !pin_prev) begin
            period_len       = ticks_since_rise;
            ticks_since_rise = '0;
          end else if (!in_if.pin_level && pin_prev) begin
            high_len = ticks_since_rise;
          end
          pin_prev = in_if.pin_level;
        end else begin
          predict_report_line();
        end
      end

      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word char=0x%02h last=%0b", $time,
                   out_if.out_char, out_if.last_char);
          mismatches++;
        end else begin
          exp_w = expected_chars.pop_front();
          if (out_if.out_char !== exp_w.ch) begin
            $display("%0t: out_char expected 0x%02h got 0x%02h", $time,
                     exp_w.ch, out_if.out_char);
            mismatches++;
          end
          if (out_if.last_char !== exp_w.is_last) begin
            $display("%0t: last_char expected %0b got %0b", $time,
                     exp_w.is_last, out_if.last_char);
            mismatches++;
          end
        end
      end
    end
    words_pending = expected_chars.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pfdm_tb_pkg::*;

  // covers the report latency at the default width with margin
  localparam int SETTLE = 128;

  logic clk = 1'b0;
  logic rst_n;
  logic out_ready = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   fail_count;
  int   pending_words;

  pfdm_in_if  in_ch();
  pfdm_out_if out_ch();
  pfdm_cfg_if cfg_ch();

  assign out_ch.ready = out_ready;

  pulse_frequency_duty_meter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  pfdm_line_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_if         (in_ch),
    .out_if        (out_ch),
    .cfg_if        (cfg_ch),
    .mismatches    (fail_count),
    .words_pending (pending_words)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_word(input logic act, input logic pin);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.pin_level <= pin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_rate(input logic [pfdm_pkg::RATE_W-1:0] hz);
    wait_drained();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.tick_rate_hz <= hz;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int seg_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 200) : $urandom_range(1, 4);
  endfunction

  // mostly clean square waves with reports dropped in right after a rising
  // edge, now and then a burst of random words
  task automatic run_waveforms(input int n_words);
    int done;
    int h;
    int l;
    done = 0;
    while (done < n_words) begin
      if ($urandom_range(0, 99) < 85) begin
        h = seg_len();
        l = seg_len();
        send_word(ACT_TICK, 1'b1);
        if ($urandom_range(0, 99) < 50) begin
          send_word(ACT_REPORT, 1'($urandom_range(0, 1)));
          done++;
        end
        repeat (h - 1) send_word(ACT_TICK, 1'b1);
        repeat (l) send_word(ACT_TICK, 1'b0);
        done += h + l;
      end else begin
        repeat (6) begin
          send_word(($urandom_range(0, 99) < 15) ? ACT_REPORT : ACT_TICK,
                    1'($urandom_range(0, 1)));
        end
        done += 6;
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= ACT_TICK;
    in_ch.pin_level     <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.tick_rate_hz <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    set_rate(24'hFFFFFF);
    send_word(ACT_REPORT, 1'b1);   // nothing measured yet: all zeros
    send_word(ACT_TICK, 1'b1);     // rising edge right out of reset, period 1
    send_word(ACT_REPORT, 1'b0);   // frequency saturates
    send_word(ACT_TICK, 1'b0);
    send_word(ACT_TICK, 1'b1);
    send_word(ACT_REPORT, 1'b1);   // period 2, half duty

    // long high time after a short period: duty saturates
    repeat (10) send_word(ACT_TICK, 1'b1);
    send_word(ACT_TICK, 1'b0);
    send_word(ACT_REPORT, 1'b0);

    set_rate(24'd1);
    send_word(ACT_REPORT, 1'b0);
    set_rate(24'd0);
    send_word(ACT_REPORT, 1'b0);
    set_rate(24'd9999999);
    send_word(ACT_REPORT, 1'b1);

    set_rate(pfdm_pkg::RATE_RST);
    run_waveforms(105);

    set_rate(24'($urandom_range(1, 9999999)));
    idle_pct = 62;
    run_waveforms(105);

    set_rate(24'($urandom_range(1, 24'hFFFFFF)));
    idle_pct = 0;
    stall_pct = 62;
    run_waveforms(105);

    set_rate(24'($urandom_range(1, 1000)));
    idle_pct = 33;
    stall_pct = 33;
    run_waveforms(105);

    wait_drained();
    if (fail_count == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
